// ===== hdl/rvnx_pkg.sv =====
// Package for the vector rotation block: shared types, the inverse CORDIC gain and a saturation helper function.
// Has no dependencies of its own; every module in hdl imports it.
`default_nettype none
package rvnx_pkg;
   localparam int VEC_W = 32;
   localparam int NRM_W = 18;
   localparam int CW = 34;
   localparam logic signed [CW-1:0] KINV_Q30 = 34'sd652032874;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
      logic signed [NRM_W-1:0] nx;
      logic signed [NRM_W-1:0] ny;
      logic signed [NRM_W-1:0] nz;
   } item_type;

   typedef struct packed {
      logic signed [CW-1:0] vx;
      logic signed [CW-1:0] vy;
      logic signed [CW-1:0] rx;
      logic signed [CW-1:0] ry;
   } cordic_type;

   function automatic logic signed [VEC_W-1:0] sat32(input logic signed [71:0] v);
      if (v > 72'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -72'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[VEC_W-1:0];
      end
   endfunction
endpackage
`default_nettype wire

// ===== hdl/rotate_vector_normal_to_x_axis.sv =====
// Top level: a chain of CORDIC cells followed by multiply, sum and saturate stages.
// Depends on rvnx_pkg and rvnx_cordic_cell.
// The square root needs 18 cells, so the chain is at least that long; one beat per cycle
// while the output is not stalled.
// The whole chain, input ready included, stalls while a result beat waits and is not taken.
// Synchronous active-high reset clears all valid bits; payload is not reset.
`default_nettype none
module rotate_vector_normal_to_x_axis
   import rvnx_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // vec_x, vec_y, vec_z, norm_x, norm_y, norm_z from the lowest bit up, then zero fill.
   input  wire logic [151:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // rot_x, rot_y, rot_z from the lowest bit up.
   output logic [95:0]       rsp_tdata
);
   localparam int FRAC_BITS = 16;
   localparam int SQ_STEPS = 18;
   localparam int NSTG = (CORDIC_STAGES > SQ_STEPS) ? CORDIC_STAGES : SQ_STEPS;
   localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRAC_BITS;

   logic hold;
   item_type it;
   logic zero_n, flip;
   logic signed [NRM_W:0] ax, ay;
   logic signed [35:0] nzsq;
   logic signed [36:0] tt;
   logic p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, rsp_tvalid_ff;

   logic        v [0:NSTG];
   cordic_type  c [0:NSTG];
   item_type    im [0:NSTG];
   logic [1:0]  fl [0:NSTG];
   logic [35:0] rm [0:NSTG];
   logic [35:0] rt [0:NSTG];
   logic [35:0] bt [0:NSTG];

   assign hold = rsp_tvalid_ff && !rsp_tready;
   assign req_tready = !hold;

   always_comb begin
      it.x = req_tdata[31:0];
      it.y = req_tdata[63:32];
      it.z = req_tdata[95:64];
      it.nx = req_tdata[113:96];
      it.ny = req_tdata[131:114];
      it.nz = req_tdata[149:132];
      zero_n = (it.nx == '0) && (it.ny == '0);
      flip = it.nx[NRM_W-1];
      ax = flip ? -NRM_W'(0) - {it.nx[NRM_W-1], it.nx} : {it.nx[NRM_W-1], it.nx};
      ay = flip ? -{it.ny[NRM_W-1], it.ny} : {it.ny[NRM_W-1], it.ny};
      nzsq = it.nz * it.nz;
      tt = 37'sd4294967296 - 37'(nzsq);
   end

   assign v[0] = req_tvalid;
   assign c[0] = '{vx: CW'(ax) <<< (30 - FRAC_BITS), vy: CW'(ay) <<< (30 - FRAC_BITS),
                   rx: KINV_Q30, ry: '0};
   assign im[0] = it;
   assign fl[0] = {zero_n, flip};
   assign rm[0] = tt[36] ? 36'd0 : tt[35:0];
   assign rt[0] = '0;
   assign bt[0] = 36'd1 << 34;

   for (genvar i = 0; i < NSTG; i++) begin : g_chain
      rvnx_cordic_cell #(
         .SHIFT((i < CORDIC_STAGES) ? i : 0),
         .ROTATE(i < CORDIC_STAGES)
      ) u_cell (
         .clock, .reset, .hold,
         .in_valid(v[i]), .in_cor(c[i]), .in_item(im[i]), .in_flags(fl[i]),
         .in_rem(rm[i]), .in_root(rt[i]), .in_bit(bt[i]),
         .out_valid(v[i+1]), .out_cor(c[i+1]), .out_item(im[i+1]), .out_flags(fl[i+1]),
         .out_rem(rm[i+1]), .out_root(rt[i+1]), .out_bit(bt[i+1])
      );
   end

   // Cells beyond the CORDIC length pass the rotation state through unchanged.
   // Stage 1: round and clamp cos and sin, negate them for a negative nx, and force 1 and 0 when nx and ny are zero.
   logic signed [CW-1:0] rxr, ryr;
   logic signed [NRM_W:0] cs_in, sn_in;
   item_type p1_it_ff, p2_it_ff;
   logic signed [NRM_W:0] cs_ff, sn_ff;
   logic signed [17:0] g_ff;

   always_comb begin
      rxr = (c[NSTG].rx + (CW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      ryr = (c[NSTG].ry + (CW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      if (rxr > ONE) rxr = ONE;
      if (rxr < -ONE) rxr = -ONE;
      if (ryr > ONE) ryr = ONE;
      if (ryr < -ONE) ryr = -ONE;
      if (fl[NSTG][0]) begin
         rxr = -rxr;
         ryr = -ryr;
      end
      if (fl[NSTG][1]) begin
         rxr = ONE;
         ryr = '0;
      end
      cs_in = rxr[NRM_W:0];
      sn_in = ryr[NRM_W:0];
   end

   // Stage 2: products.
   logic signed [50:0] pxn_ff, pyn_ff, pzn_ff, pyc_ff, pxs_ff, pxc_ff, pys_ff, pzg_ff;
   // Stage 3: sums.
   logic signed [71:0] sx_ff, sy_ff, su_ff;
   logic signed [50:0] zg3_ff;
   logic signed [NRM_W-1:0] nz3_ff;
   logic signed [71:0] ur;
   // Stage 4: u*nz.
   logic signed [71:0] rx4_ff, ry4_ff, zg4_ff, unz_ff;
   logic signed [71:0] zsum;
   logic [95:0] rsp_tdata_ff;

   always_comb begin
      ur = (su_ff + 72'sd32768) >>> FRAC_BITS;
      zsum = zg4_ff - unz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (!hold) begin
         p1_v_ff <= v[NSTG];
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
         rsp_tvalid_ff <= p4_v_ff;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_ff;
      end
      if (!hold) begin
         p1_it_ff <= im[NSTG];
         cs_ff <= cs_in;
         sn_ff <= sn_in;
         g_ff <= rt[NSTG][17:0];
         p2_it_ff <= p1_it_ff;
         pxn_ff <= p1_it_ff.x * p1_it_ff.nx;
         pyn_ff <= p1_it_ff.y * p1_it_ff.ny;
         pzn_ff <= p1_it_ff.z * p1_it_ff.nz;
         pyc_ff <= p1_it_ff.y * cs_ff;
         pxs_ff <= p1_it_ff.x * sn_ff;
         pxc_ff <= p1_it_ff.x * cs_ff;
         pys_ff <= p1_it_ff.y * sn_ff;
         pzg_ff <= p1_it_ff.z * $signed({1'b0, g_ff});
         sx_ff <= 72'(pxn_ff) + 72'(pyn_ff) + 72'(pzn_ff);
         sy_ff <= 72'(pyc_ff) - 72'(pxs_ff);
         su_ff <= 72'(pxc_ff) + 72'(pys_ff);
         zg3_ff <= pzg_ff;
         nz3_ff <= p2_it_ff.nz;
         rx4_ff <= sx_ff;
         ry4_ff <= sy_ff;
         zg4_ff <= 72'(zg3_ff);
         unz_ff <= 72'($signed(ur[53:0]) * nz3_ff);
         rsp_tdata_ff <= {sat32((zsum + 72'sd32768) >>> FRAC_BITS),
                          sat32((ry4_ff + 72'sd32768) >>> FRAC_BITS),
                          sat32((rx4_ff + 72'sd32768) >>> FRAC_BITS)};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat lost under stall");
   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      hold |-> !req_tready)
      else $error("input taken while pipeline stalled");
   a_adv: assert property (@(posedge clock) disable iff (reset)
      !hold |=> rsp_tvalid == $past(p4_v_ff))
      else $error("pipeline valid did not advance");
endmodule
`default_nettype wire

// ===== hdl/rvnx_cordic_cell.sv =====
// One CORDIC vectoring cell with delay line for the item and a square-root digit step.
// Depends on rvnx_pkg.
`default_nettype none
module rvnx_cordic_cell
   import rvnx_pkg::*;
#(
   parameter int SHIFT = 0,
   parameter bit ROTATE = 1'b1
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire cordic_type in_cor,
   input  wire item_type   in_item,
   input  wire logic [1:0] in_flags,
   input  wire logic [35:0] in_rem,
   input  wire logic [35:0] in_root,
   input  wire logic [35:0] in_bit,
   input  wire logic       hold,
   output logic            out_valid,
   output cordic_type      out_cor,
   output item_type        out_item,
   output logic [1:0]      out_flags,
   output logic [35:0]     out_rem,
   output logic [35:0]     out_root,
   output logic [35:0]     out_bit
);
   cordic_type cor_in;
   logic [35:0] rem_in, root_in;
   logic valid_ff;
   cordic_type cor_ff;
   item_type item_ff;
   logic [1:0] flags_ff;
   logic [35:0] rem_ff, root_ff, bit_ff;

   always_comb begin
      if (!ROTATE) begin
         cor_in = in_cor;
      end else if (in_cor.vy > 0) begin
         cor_in.vx = in_cor.vx + (in_cor.vy >>> SHIFT);
         cor_in.vy = in_cor.vy - (in_cor.vx >>> SHIFT);
         cor_in.rx = in_cor.rx - (in_cor.ry >>> SHIFT);
         cor_in.ry = in_cor.ry + (in_cor.rx >>> SHIFT);
      end else begin
         cor_in.vx = in_cor.vx - (in_cor.vy >>> SHIFT);
         cor_in.vy = in_cor.vy + (in_cor.vx >>> SHIFT);
         cor_in.rx = in_cor.rx + (in_cor.ry >>> SHIFT);
         cor_in.ry = in_cor.ry - (in_cor.rx >>> SHIFT);
      end
      if (in_bit == '0) begin
         rem_in = in_rem;
         root_in = in_root;
      end else if (in_rem >= in_root + in_bit) begin
         rem_in = in_rem - (in_root + in_bit);
         root_in = (in_root >> 1) + in_bit;
      end else begin
         rem_in = in_rem;
         root_in = in_root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!hold) begin
         valid_ff <= in_valid;
      end
      if (!hold) begin
         cor_ff <= cor_in;
         item_ff <= in_item;
         flags_ff <= in_flags;
         rem_ff <= rem_in;
         root_ff <= root_in;
         bit_ff <= in_bit >> 2;
      end
   end

   assign out_valid = valid_ff;
   assign out_cor = cor_ff;
   assign out_item = item_ff;
   assign out_flags = flags_ff;
   assign out_rem = rem_ff;
   assign out_root = root_ff;
   assign out_bit = bit_ff;
endmodule
`default_nettype wire
